FILE: rtl/core/csvds_pkg.sv
`default_nettype none

package csvds_pkg;

    // default counter widths
    localparam int ROW_BITS_DEF  = 32;
    localparam int SIZE_BITS_DEF = 16;

    // result field widths
    localparam int ROW_OUT_W  = 32;
    localparam int SIZE_OUT_W = 16;

    // character codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] SEP_RESET = 8'h2C;

    // lookahead held over from the previous byte
    typedef enum logic [3:0] {
        PEND_NONE  = 4'b0001,
        PEND_QUOTE = 4'b0010,
        PEND_ESC   = 4'b0100,
        PEND_CR    = 4'b1000
    } pend_t;

    // scanner flags shared between the top level and the step logic
    typedef struct packed {
        logic  inside_quotes;
        pend_t pending;
        logic  saturated;
    } scan_flags_t;

endpackage

`default_nettype wire

FILE: rtl/core/csvds_if.sv
`default_nettype none

// input channel: one byte or an end-of-stream marker per transaction
interface csvds_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// result channel: totals of one stream per transaction
interface csvds_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] row_count;
    logic [15:0] max_columns;
    logic [15:0] widest_cell;
    logic        overflowed;

    modport source (output valid, output row_count, output max_columns,
                    output widest_cell, output overflowed, input ready);
    modport sink   (input valid, input row_count, input max_columns,
                    input widest_cell, input overflowed, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/csvds_step.sv
`default_nettype none

module csvds_step #(
    parameter int ROW_BITS  = csvds_pkg::ROW_BITS_DEF,
    parameter int SIZE_BITS = csvds_pkg::SIZE_BITS_DEF
) (
    input  wire logic [7:0]             data_byte,
    input  wire logic                   end_of_stream,
    input  wire logic [7:0]             separator,
    input  wire csvds_pkg::scan_flags_t flags,
    input  wire logic [ROW_BITS-1:0]    rows,
    input  wire logic [SIZE_BITS-1:0]   fields,
    input  wire logic [SIZE_BITS-1:0]   cell_len,
    input  wire logic [SIZE_BITS-1:0]   widest,
    input  wire logic [SIZE_BITS-1:0]   longest,
    output csvds_pkg::scan_flags_t      flags_next,
    output logic [ROW_BITS-1:0]         rows_next,
    output logic [SIZE_BITS-1:0]        fields_next,
    output logic [SIZE_BITS-1:0]        cell_len_next,
    output logic [SIZE_BITS-1:0]        widest_next,
    output logic [SIZE_BITS-1:0]        longest_next,
    output logic [csvds_pkg::ROW_OUT_W-1:0]  row_count,
    output logic [csvds_pkg::SIZE_OUT_W-1:0] max_columns,
    output logic [csvds_pkg::SIZE_OUT_W-1:0] widest_cell
);
    import csvds_pkg::*;

    localparam logic [ROW_BITS-1:0]  ROW_MAX  = '1;
    localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;
    localparam logic [SIZE_BITS-1:0] SIZE_ONE = SIZE_BITS'(1);

    logic                 handle;
    logic                 is_sep;
    logic [SIZE_BITS-1:0] cols;
    logic [SIZE_BITS-1:0] cells;

    // totals for an end-of-stream transaction, masked to the result widths
    always_comb
    begin
        cols  = (fields > widest) ? fields : widest;
        cells = (cell_len > longest) ? cell_len : longest;
        row_count   = ROW_OUT_W'(rows);
        max_columns = SIZE_OUT_W'(cols);
        widest_cell = SIZE_OUT_W'(cells);
    end

    // next state for one accepted byte
    always_comb
    begin
        flags_next    = flags;
        rows_next     = rows;
        fields_next   = fields;
        cell_len_next = cell_len;
        widest_next   = widest;
        longest_next  = longest;
        handle        = 1'b0;
        is_sep        = (data_byte == separator);

        if (end_of_stream)
        begin
            flags_next.inside_quotes = 1'b0;
            flags_next.pending       = PEND_NONE;
            flags_next.saturated     = 1'b0;
            rows_next     = '0;
            fields_next   = SIZE_ONE;
            cell_len_next = SIZE_ONE;
            widest_next   = SIZE_ONE;
            longest_next  = SIZE_ONE;
        end
        else
        begin
            flags_next.pending = PEND_NONE;
            handle = 1'b1;

            // resolve the lookahead from the previous byte
            case (flags.pending)
                PEND_ESC:
                begin
                    handle = 1'b0;
                end
                PEND_CR:
                begin
                    if (data_byte == CH_LF)
                    begin
                        handle = 1'b0;
                    end
                end
                PEND_QUOTE:
                begin
                    if (data_byte == CH_QUOTE)
                    begin
                        handle = 1'b0;
                        if (cell_len_next == SIZE_MAX)
                            flags_next.saturated = 1'b1;
                        else
                            cell_len_next = cell_len_next + SIZE_ONE;
                    end
                    else if (data_byte == CH_CR || data_byte == CH_LF || is_sep)
                    begin
                        flags_next.inside_quotes = 1'b0;
                    end
                end
                default:
                begin
                    handle = 1'b1;
                end
            endcase

            // ordinary byte handling, separator checked first
            if (handle)
            begin
                if (is_sep)
                begin
                    if (flags_next.inside_quotes)
                    begin
                        if (cell_len_next == SIZE_MAX)
                            flags_next.saturated = 1'b1;
                        else
                            cell_len_next = cell_len_next + SIZE_ONE;
                    end
                    else
                    begin
                        if (cell_len_next > longest_next)
                            longest_next = cell_len_next;
                        cell_len_next = SIZE_ONE;
                        if (fields_next == SIZE_MAX)
                            flags_next.saturated = 1'b1;
                        else
                            fields_next = fields_next + SIZE_ONE;
                    end
                end
                else if (data_byte == CH_QUOTE)
                begin
                    if (flags_next.inside_quotes)
                        flags_next.pending = PEND_QUOTE;
                    else if (cell_len_next == SIZE_ONE)
                        flags_next.inside_quotes = 1'b1;
                end
                else if (data_byte == CH_BSLASH)
                begin
                    if (cell_len_next == SIZE_MAX)
                        flags_next.saturated = 1'b1;
                    else
                        cell_len_next = cell_len_next + SIZE_ONE;
                    flags_next.pending = PEND_ESC;
                end
                else if ((data_byte == CH_CR || data_byte == CH_LF)
                         && !flags_next.inside_quotes)
                begin
                    // line ending outside quotes
                    if (rows_next == ROW_MAX)
                        flags_next.saturated = 1'b1;
                    else
                        rows_next = rows_next + ROW_BITS'(1);
                    if (fields_next > widest_next)
                        widest_next = fields_next;
                    if (cell_len_next > longest_next)
                        longest_next = cell_len_next;
                    cell_len_next = SIZE_ONE;
                    fields_next   = SIZE_ONE;
                    flags_next.inside_quotes = 1'b0;
                    if (data_byte == CH_CR)
                        flags_next.pending = PEND_CR;
                end
                else
                begin
                    if (cell_len_next == SIZE_MAX)
                        flags_next.saturated = 1'b1;
                    else
                        cell_len_next = cell_len_next + SIZE_ONE;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/csv_dimension_scanner.sv
`default_nettype none

// channel     dir  transaction
// byte_in     in   one text byte, or end_of_stream with no byte
// result_out  out  row_count, max_columns, widest_cell, overflowed of one stream
// cfg_we/data in   write of the separator byte, taken on any rising edge with cfg_we high
//
// One byte per cycle: the scan state updates at the accepting edge and a
// result lands in the output register at that same edge, visible next cycle.
// byte_in.ready is low only while a result sits in the output register and
// result_out.ready is low. Reset clears the scan state, drops any pending
// result and sets the separator to a comma.
module csv_dimension_scanner #(
    parameter int ROW_BITS  = csvds_pkg::ROW_BITS_DEF,
    parameter int SIZE_BITS = csvds_pkg::SIZE_BITS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_data,
    csvds_in_if.sink        byte_in,
    csvds_out_if.source     result_out
);
    import csvds_pkg::*;

    logic [7:0]           separator_reg;
    scan_flags_t          flags_reg, flags_next;
    logic [ROW_BITS-1:0]  rows_reg, rows_next;
    logic [SIZE_BITS-1:0] fields_reg, fields_next;
    logic [SIZE_BITS-1:0] cell_len_reg, cell_len_next;
    logic [SIZE_BITS-1:0] widest_reg, widest_next;
    logic [SIZE_BITS-1:0] longest_reg, longest_next;

    logic                  out_valid_reg;
    logic [ROW_OUT_W-1:0]  row_count_reg;
    logic [SIZE_OUT_W-1:0] max_columns_reg;
    logic [SIZE_OUT_W-1:0] widest_cell_reg;
    logic                  overflowed_reg;

    logic [ROW_OUT_W-1:0]  row_count;
    logic [SIZE_OUT_W-1:0] max_columns;
    logic [SIZE_OUT_W-1:0] widest_cell;
    logic                  in_fire;
    logic                  res_fire;

    assign byte_in.ready = !out_valid_reg || result_out.ready;
    assign in_fire       = byte_in.valid && byte_in.ready;
    assign res_fire      = in_fire && byte_in.end_of_stream;

    // per-byte scan logic
    csvds_step #(
        .ROW_BITS  (ROW_BITS),
        .SIZE_BITS (SIZE_BITS)
    ) u_step (
        .data_byte     (byte_in.data_byte),
        .end_of_stream (byte_in.end_of_stream),
        .separator     (separator_reg),
        .flags         (flags_reg),
        .rows          (rows_reg),
        .fields        (fields_reg),
        .cell_len      (cell_len_reg),
        .widest        (widest_reg),
        .longest       (longest_reg),
        .flags_next    (flags_next),
        .rows_next     (rows_next),
        .fields_next   (fields_next),
        .cell_len_next (cell_len_next),
        .widest_next   (widest_next),
        .longest_next  (longest_next),
        .row_count     (row_count),
        .max_columns   (max_columns),
        .widest_cell   (widest_cell)
    );

    // separator register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            separator_reg <= SEP_RESET;
        else if (cfg_we)
            separator_reg <= cfg_data;
    end

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg.inside_quotes <= 1'b0;
            flags_reg.pending       <= PEND_NONE;
            flags_reg.saturated     <= 1'b0;
            rows_reg     <= '0;
            fields_reg   <= SIZE_BITS'(1);
            cell_len_reg <= SIZE_BITS'(1);
            widest_reg   <= SIZE_BITS'(1);
            longest_reg  <= SIZE_BITS'(1);
        end
        else if (in_fire)
        begin
            flags_reg    <= flags_next;
            rows_reg     <= rows_next;
            fields_reg   <= fields_next;
            cell_len_reg <= cell_len_next;
            widest_reg   <= widest_next;
            longest_reg  <= longest_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_fire)
            out_valid_reg <= 1'b1;
        else if (result_out.ready)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            row_count_reg   <= row_count;
            max_columns_reg <= max_columns;
            widest_cell_reg <= widest_cell;
            overflowed_reg  <= flags_reg.saturated;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.row_count   = row_count_reg;
    assign result_out.max_columns = max_columns_reg;
    assign result_out.widest_cell = widest_cell_reg;
    assign result_out.overflowed  = overflowed_reg;

endmodule

`default_nettype wire
